>>> sv/caapf_pkg.sv
// Shared types and constants for the coverage anti-alias pixel filter.
package caapf_pkg;

    localparam int unsigned NUM_NBR  = 6;
    localparam int unsigned CHAN_W   = 5;
    localparam int unsigned COV_W    = 4;
    localparam int unsigned PIX_W    = 16;

    // RGBA5551 channel positions (low bit of each field)
    localparam int unsigned RED_LSB  = 11;
    localparam int unsigned GRN_LSB  = 6;
    localparam int unsigned BLU_LSB  = 1;

    localparam logic [COV_W-1:0] FULL_COV = 4'd8;

    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [COV_W-1:0]  t_cov;
    typedef logic [PIX_W-1:0]  t_pix;

    // One neighbourhood beat as held in the input stage
    typedef struct packed {
        t_pix        center_color;
        t_cov        center_coverage;
        t_pix        upper_left_color;
        t_pix        upper_right_color;
        t_pix        far_left_color;
        t_pix        far_right_color;
        t_pix        lower_left_color;
        t_pix        lower_right_color;
        logic [23:0] neighbor_coverages;
    } t_nbhd;

    function automatic t_chan get_chan(input t_pix pix, input int unsigned lsb);
        get_chan = pix[lsb +: CHAN_W];
    endfunction

endpackage

>>> sv/caapf_if.sv
// Valid/ready channel interfaces for the neighbourhood input and the pixel output.
interface caapf_nbhd_if;
    logic                 valid;
    logic                 ready;
    caapf_pkg::t_pix      center_color;
    caapf_pkg::t_cov      center_coverage;
    caapf_pkg::t_pix      upper_left_color;
    caapf_pkg::t_pix      upper_right_color;
    caapf_pkg::t_pix      far_left_color;
    caapf_pkg::t_pix      far_right_color;
    caapf_pkg::t_pix      lower_left_color;
    caapf_pkg::t_pix      lower_right_color;
    logic [23:0]          neighbor_coverages;

    modport source (
        output valid, center_color, center_coverage, upper_left_color, upper_right_color,
               far_left_color, far_right_color, lower_left_color, lower_right_color,
               neighbor_coverages,
        input  ready
    );
    modport sink (
        input  valid, center_color, center_coverage, upper_left_color, upper_right_color,
               far_left_color, far_right_color, lower_left_color, lower_right_color,
               neighbor_coverages,
        output ready
    );
endinterface

interface caapf_pix_if;
    logic            valid;
    logic            ready;
    caapf_pkg::t_pix filtered_pixel;

    modport source (output valid, filtered_pixel, input ready);
    modport sink   (input valid, filtered_pixel, output ready);
endinterface

>>> sv/caapf_channel.sv
// Per-channel blend of the centre value toward the neighbour-derived value.
module caapf_channel (
    input  caapf_pkg::t_chan                     i_centre,
    input  logic [2:0]                           i_cov,
    input  caapf_pkg::t_chan [caapf_pkg::NUM_NBR-1:0] i_vals,
    input  logic [caapf_pkg::NUM_NBR-1:0]        i_use,
    output caapf_pkg::t_chan                     o_chan
);

    caapf_pkg::t_chan min1;
    caapf_pkg::t_chan min2;
    caapf_pkg::t_chan max1;
    logic [2:0]       cnt;
    logic             two_plus;
    caapf_pkg::t_chan lo;
    caapf_pkg::t_chan hi;
    logic [5:0]       f_sum;
    caapf_pkg::t_chan f_val;
    logic [3:0]       w_nbr;
    logic [8:0]       blend;

    // Unused neighbours pad as all-ones for the min path and zero for the max path;
    // with two or more counted, the second smallest is what is left after the drop.
    always_comb begin
        min1 = '1;
        min2 = '1;
        max1 = '0;
        cnt  = '0;
        for (int k = 0; k < caapf_pkg::NUM_NBR; k++) begin
            if (i_use[k]) begin
                cnt = cnt + 3'd1;
                if (i_vals[k] < min1) begin
                    min2 = min1;
                    min1 = i_vals[k];
                end else if (i_vals[k] < min2) begin
                    min2 = i_vals[k];
                end
                if (i_vals[k] > max1) begin
                    max1 = i_vals[k];
                end
            end
        end
    end

    assign two_plus = (cnt >= 3'd2);
    assign lo       = (two_plus && (min2 < i_centre)) ? min2 : i_centre;
    assign hi       = (two_plus && (max1 > i_centre)) ? max1 : i_centre;

    // lo <= centre <= hi, so the result stays within 0..31
    assign f_sum = {1'b0, hi} + {1'b0, lo} - {1'b0, i_centre};
    assign f_val = f_sum[4:0];

    assign w_nbr = caapf_pkg::FULL_COV - {1'b0, i_cov};
    assign blend = 9'(i_centre * i_cov) + 9'(f_val * w_nbr);
    assign o_chan = blend[7:3];

endmodule

>>> sv/coverage_antialias_pixel_filter.sv
// Top level: coverage anti-alias filter for one RGBA5551 pixel per beat.
//
// Input channel i_nbhd carries one neighbourhood per beat: the centre colour and
// coverage, six neighbour colours and their packed 4-bit coverages. Output channel
// o_pixel carries the filtered RGBA5551 pixel, bit 0 always set. Both are
// valid/ready; a beat moves when valid and ready are high at a clock edge.
//
// Two register stages: an input register and a result register, with the
// channel filters between them; an accepted beat goes through both to o_pixel.
// One beat per cycle is sustained while o_pixel.ready stays high; the three
// channel units run in parallel on the input register.
//
// A stalled receiver holds the result register; the input register still takes
// one more beat, and i_nbhd.ready drops only when both stages are full.
// Synchronous reset (i_rst_n low) empties both stages; no result is pending.
module coverage_antialias_pixel_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    caapf_nbhd_if.sink  i_nbhd,
    caapf_pix_if.source o_pixel
);

    logic               r_s1_valid;
    caapf_pkg::t_nbhd   r_s1;
    logic               r_out_valid;
    caapf_pkg::t_pix    r_out_pixel;

    logic               out_en;
    logic               s1_ready;
    logic               s1_take;

    logic [caapf_pkg::NUM_NBR-1:0]                 nbr_use;
    caapf_pkg::t_pix  [caapf_pkg::NUM_NBR-1:0]     nbr_pix;
    caapf_pkg::t_chan [caapf_pkg::NUM_NBR-1:0]     red_vals;
    caapf_pkg::t_chan [caapf_pkg::NUM_NBR-1:0]     grn_vals;
    caapf_pkg::t_chan [caapf_pkg::NUM_NBR-1:0]     blu_vals;
    caapf_pkg::t_chan red_out;
    caapf_pkg::t_chan grn_out;
    caapf_pkg::t_chan blu_out;
    caapf_pkg::t_pix  n_out_pixel;

    assign out_en   = !r_out_valid || o_pixel.ready;
    assign s1_ready = !r_s1_valid || out_en;
    assign s1_take  = i_nbhd.valid && s1_ready;

    assign i_nbhd.ready           = s1_ready;
    assign o_pixel.valid          = r_out_valid;
    assign o_pixel.filtered_pixel = r_out_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_nbhd.valid;
        end
        if (s1_take) begin
            r_s1.center_color       <= i_nbhd.center_color;
            r_s1.center_coverage    <= i_nbhd.center_coverage;
            r_s1.upper_left_color   <= i_nbhd.upper_left_color;
            r_s1.upper_right_color  <= i_nbhd.upper_right_color;
            r_s1.far_left_color     <= i_nbhd.far_left_color;
            r_s1.far_right_color    <= i_nbhd.far_right_color;
            r_s1.lower_left_color   <= i_nbhd.lower_left_color;
            r_s1.lower_right_color  <= i_nbhd.lower_right_color;
            r_s1.neighbor_coverages <= i_nbhd.neighbor_coverages;
        end
    end

    assign nbr_pix[0] = r_s1.upper_left_color;
    assign nbr_pix[1] = r_s1.upper_right_color;
    assign nbr_pix[2] = r_s1.far_left_color;
    assign nbr_pix[3] = r_s1.far_right_color;
    assign nbr_pix[4] = r_s1.lower_left_color;
    assign nbr_pix[5] = r_s1.lower_right_color;

    always_comb begin
        for (int k = 0; k < caapf_pkg::NUM_NBR; k++) begin
            nbr_use[k]  = (r_s1.neighbor_coverages[4*k +: 4] == caapf_pkg::FULL_COV);
            red_vals[k] = caapf_pkg::get_chan(nbr_pix[k], caapf_pkg::RED_LSB);
            grn_vals[k] = caapf_pkg::get_chan(nbr_pix[k], caapf_pkg::GRN_LSB);
            blu_vals[k] = caapf_pkg::get_chan(nbr_pix[k], caapf_pkg::BLU_LSB);
        end
    end

    caapf_channel u_red (
        .i_centre (caapf_pkg::get_chan(r_s1.center_color, caapf_pkg::RED_LSB)),
        .i_cov    (r_s1.center_coverage[2:0]),
        .i_vals   (red_vals),
        .i_use    (nbr_use),
        .o_chan   (red_out)
    );

    caapf_channel u_grn (
        .i_centre (caapf_pkg::get_chan(r_s1.center_color, caapf_pkg::GRN_LSB)),
        .i_cov    (r_s1.center_coverage[2:0]),
        .i_vals   (grn_vals),
        .i_use    (nbr_use),
        .o_chan   (grn_out)
    );

    caapf_channel u_blu (
        .i_centre (caapf_pkg::get_chan(r_s1.center_color, caapf_pkg::BLU_LSB)),
        .i_cov    (r_s1.center_coverage[2:0]),
        .i_vals   (blu_vals),
        .i_use    (nbr_use),
        .o_chan   (blu_out)
    );

    // Coverage 8..15 passes the centre through untouched
    assign n_out_pixel = r_s1.center_coverage[3] ? (r_s1.center_color | 16'd1)
                                                 : {red_out, grn_out, blu_out, 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= r_s1_valid;
        end
        if (out_en && r_s1_valid) begin
            r_out_pixel <= n_out_pixel;
        end
    end

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_en) |=> r_out_valid)
        else $error("filled input stage did not reach result register");

    a_alpha_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_pixel[0])
        else $error("result beat without alpha bit");

    a_full_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_en && r_s1.center_coverage[3])
            |=> (r_out_pixel[15:1] == $past(r_s1.center_color[15:1])))
        else $error("fully covered pixel was altered");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_en) |=> (r_s1_valid && $stable(r_s1)))
        else $error("input stage changed while result register stalled");

endmodule
